// ===== rtl/rhsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the readout header stream checker.
// No dependencies; every other file of the block imports this package.
package rhsc_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned ERR_W     = 9;
    localparam int unsigned CHK_N     = 8;

    // check_enable bit positions; error_flags bit is position + 1
    localparam int unsigned CHK_PAGE_CNT  = 0;
    localparam int unsigned CHK_PACKET    = 1;
    localparam int unsigned CHK_HB_PER_TF = 2;
    localparam int unsigned CHK_FIRST     = 3;
    localparam int unsigned CHK_STOP_1ST  = 4;
    localparam int unsigned CHK_NO_STOP   = 5;
    localparam int unsigned CHK_JUMP      = 6;
    localparam int unsigned CHK_NO_SP     = 7;
    localparam int unsigned ERR_FEE_ID    = 0;

    localparam logic [7:0]  CHECK_ENABLE_RST = 8'hff;
    localparam logic [15:0] ORBITS_PER_TF_RST = 16'd256;
    localparam logic [31:0] TF_MASK_RST      = 32'h0000_0800;
    localparam logic [31:0] HB_MASK_RST      = 32'h0000_0003;

    localparam logic [15:0] HB_PER_TF_MAX = 16'hffff;
    localparam logic [31:0] BYTES_MAX     = 32'hffff_ffff;

    // block_start_kind bits
    localparam int unsigned KIND_TF = 0;
    localparam int unsigned KIND_SP = 1;
    localparam int unsigned KIND_HB = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_ENABLE  = 8'd0,
        CFG_ORBITS_PER_TF = 8'd1,
        CFG_TF_MASK       = 8'd2,
        CFG_HB_MASK       = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  check_enable;
        logic [15:0] orbits_per_timeframe;
        logic [31:0] timeframe_trigger_mask;
        logic [31:0] heartbeat_trigger_mask;
    } cfg_t;

    typedef struct packed {
        logic [15:0] fee_id;
        logic [15:0] page_counter;
        logic [7:0]  packet_counter;
        logic [31:0] trigger_type;
        logic [31:0] heartbeat_orbit;
        logic [11:0] heartbeat_bc;
        logic        stop_bit;
        logic [15:0] page_bytes;
        logic        new_superpage;
        logic        multi_link_stream;
    } hdr_t;

    typedef struct packed {
        logic [ERR_W-1:0] error_flags;
        logic             opens_block;
        logic [2:0]       block_start_kind;
        logic [31:0]      block_orbit;
        logic [31:0]      block_timeframe_index;
        logic [31:0]      block_bytes;
        logic             heartbeat_ended;
    } res_t;

endpackage

// ===== rtl/rhsc_hdr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one page header per transfer.
// Depends on rhsc_pkg for hdr_t.
interface rhsc_hdr_if;
    import rhsc_pkg::*;

    logic valid;
    logic ready;
    hdr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rhsc_res_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one check result per transfer.
// Depends on rhsc_pkg for res_t.
interface rhsc_res_if;
    import rhsc_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rhsc_cfg_if.sv =====
`timescale 1ns / 1ps
// Register write channel: index and write data with valid/ready.
// Depends on rhsc_pkg for the index width.
interface rhsc_cfg_if;
    import rhsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/rhsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file of the header checker.
// Depends on rhsc_pkg and rhsc_cfg_if.
module rhsc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    rhsc_cfg_if.sink            cfg,
    output rhsc_pkg::cfg_t      regs
);
    import rhsc_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_CHECK_ENABLE:  regs_next.check_enable = cfg.wdata[7:0];
                CFG_ORBITS_PER_TF: regs_next.orbits_per_timeframe = cfg.wdata[15:0];
                CFG_TF_MASK:       regs_next.timeframe_trigger_mask = cfg.wdata;
                CFG_HB_MASK:       regs_next.heartbeat_trigger_mask = cfg.wdata;
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.check_enable           <= CHECK_ENABLE_RST;
            regs_reg.orbits_per_timeframe   <= ORBITS_PER_TF_RST;
            regs_reg.timeframe_trigger_mask <= TF_MASK_RST;
            regs_reg.heartbeat_trigger_mask <= HB_MASK_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== rtl/rhsc_core.sv =====
`timescale 1ns / 1ps
// Per-link header state and the combinational check and block tracking logic.
// Depends on rhsc_pkg.
module rhsc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  rhsc_pkg::hdr_t  hdr,
    input  rhsc_pkg::cfg_t  cfg,
    output rhsc_pkg::res_t  res
);
    import rhsc_pkg::*;

    logic        seen_reg;
    logic [15:0] prev_fee_reg;
    logic [15:0] prev_page_reg;
    logic [7:0]  prev_pkt_reg;
    logic [31:0] prev_orbit_reg;
    logic [11:0] prev_bc_reg;
    logic [15:0] hb_in_tf_reg,   hb_in_tf_next;
    logic        hb_open_reg,    hb_open_next;
    logic [31:0] tf_count_reg,   tf_count_next;
    logic [31:0] blk_bytes_reg,  blk_bytes_next;
    logic [31:0] blk_orbit_reg,  blk_orbit_next;
    logic [31:0] blk_index_reg,  blk_index_next;
    logic [2:0]  blk_kind_reg,   blk_kind_next;

    logic             first;
    logic             page_zero;
    logic             new_tf;
    logic             new_hb;
    logic             opens;
    logic             any_en;
    logic [CHK_N-1:0] en;
    logic [ERR_W-1:0] flags;
    logic [15:0]      hb_cleared;
    logic [31:0]      bytes_base;
    logic [32:0]      bytes_sum;

    always_comb
    begin
        en        = cfg.check_enable;
        any_en    = |en;
        first     = !seen_reg;
        page_zero = (hdr.page_counter == '0);
        new_tf    = page_zero && ((hdr.trigger_type & cfg.timeframe_trigger_mask) != '0);
        new_hb    = page_zero && ((hdr.trigger_type & cfg.heartbeat_trigger_mask)
                                  == cfg.heartbeat_trigger_mask);
        opens     = new_tf || hdr.new_superpage || new_hb;

        flags = '0;
        flags[ERR_FEE_ID] = !first && (hdr.fee_id != prev_fee_reg);
        flags[CHK_PAGE_CNT+1] = en[CHK_PAGE_CNT] && !page_zero && !first
                                && (hdr.page_counter != prev_page_reg + 16'd1);
        flags[CHK_PACKET+1] = en[CHK_PACKET] && !first
                              && (hdr.packet_counter != prev_pkt_reg + 8'd1);
        flags[CHK_HB_PER_TF+1] = en[CHK_HB_PER_TF] && !first && new_tf
                                 && (hb_in_tf_reg != cfg.orbits_per_timeframe);
        flags[CHK_FIRST+1] = en[CHK_FIRST] && first && !(new_tf && new_hb);
        flags[CHK_STOP_1ST+1] = en[CHK_STOP_1ST] && new_hb && hdr.stop_bit;
        flags[CHK_NO_STOP+1] = en[CHK_NO_STOP] && new_hb && hb_open_reg;
        flags[CHK_JUMP+1] = en[CHK_JUMP] && new_hb && !first
                            && !((hdr.heartbeat_bc == prev_bc_reg)
                                 && (hdr.heartbeat_orbit == prev_orbit_reg + 32'd1));
        flags[CHK_NO_SP+1] = en[CHK_NO_SP] && new_tf && hdr.multi_link_stream
                             && !hdr.new_superpage;

        // heartbeat-per-timeframe count only runs while some check is on
        hb_cleared    = (any_en && !first && new_tf) ? '0 : hb_in_tf_reg;
        hb_in_tf_next = hb_cleared;
        if (any_en && new_hb && (hb_cleared != HB_PER_TF_MAX))
            hb_in_tf_next = hb_cleared + 16'd1;

        hb_open_next = hb_open_reg;
        if (new_hb)
            hb_open_next = 1'b1;
        if (hdr.stop_bit)
            hb_open_next = 1'b0;

        tf_count_next = tf_count_reg + {31'd0, new_tf};

        blk_kind_next  = blk_kind_reg;
        blk_orbit_next = blk_orbit_reg;
        blk_index_next = blk_index_reg;
        if (opens)
        begin
            blk_kind_next[KIND_TF] = new_tf;
            blk_kind_next[KIND_SP] = hdr.new_superpage;
            blk_kind_next[KIND_HB] = new_hb;
            blk_orbit_next         = hdr.heartbeat_orbit;
            // equals the incremented timeframe count minus one
            blk_index_next         = tf_count_reg - {31'd0, !new_tf};
        end

        bytes_base     = opens ? '0 : blk_bytes_reg;
        bytes_sum      = {1'b0, bytes_base} + {17'd0, hdr.page_bytes};
        blk_bytes_next = bytes_sum[32] ? BYTES_MAX : bytes_sum[31:0];

        res.error_flags           = flags;
        res.opens_block           = opens;
        res.block_start_kind      = blk_kind_next;
        res.block_orbit           = blk_orbit_next;
        res.block_timeframe_index = blk_index_next;
        res.block_bytes           = blk_bytes_next;
        res.heartbeat_ended       = hdr.stop_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            prev_fee_reg   <= '0;
            prev_page_reg  <= '0;
            prev_pkt_reg   <= '0;
            prev_orbit_reg <= '0;
            prev_bc_reg    <= '0;
            hb_in_tf_reg   <= '0;
            hb_open_reg    <= 1'b0;
            tf_count_reg   <= '0;
            blk_bytes_reg  <= '0;
            blk_orbit_reg  <= '0;
            blk_index_reg  <= '0;
            blk_kind_reg   <= '0;
        end
        else if (step)
        begin
            seen_reg       <= 1'b1;
            prev_fee_reg   <= hdr.fee_id;
            prev_page_reg  <= hdr.page_counter;
            prev_pkt_reg   <= hdr.packet_counter;
            prev_orbit_reg <= hdr.heartbeat_orbit;
            prev_bc_reg    <= hdr.heartbeat_bc;
            hb_in_tf_reg   <= hb_in_tf_next;
            hb_open_reg    <= hb_open_next;
            tf_count_reg   <= tf_count_next;
            blk_bytes_reg  <= blk_bytes_next;
            blk_orbit_reg  <= blk_orbit_next;
            blk_index_reg  <= blk_index_next;
            blk_kind_reg   <= blk_kind_next;
        end
    end

endmodule

// ===== rtl/readout_header_stream_checker.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                       Transfer when
// header    in   rhsc_pkg::hdr_t page header   header.valid && header.ready
// result    out  rhsc_pkg::res_t check result  result.valid && result.ready
// cfg       in   8-bit index, 32-bit data      cfg.valid && cfg.ready (ready tied high)
//
// One header per cycle sustained while the result side is ready. A header transfer loads
// the input register, and the result register loads from it when the header is checked.
// The link state updates as the header moves into the result register, in the same cycle,
// which sets the rate.
// rst_n clears all link state and loads the register reset values.
// While a result is stalled the input register takes one more header, then input stalls.
// Depends on rhsc_pkg, the three channel interfaces, rhsc_cfg_regs and rhsc_core.
module readout_header_stream_checker (
    input  logic         clk,
    input  logic         rst_n,
    rhsc_hdr_if.sink     header,
    rhsc_res_if.source   result,
    rhsc_cfg_if.sink     cfg
);
    import rhsc_pkg::*;

    logic in_vld_reg,  in_vld_next;
    hdr_t in_data_reg;
    logic out_vld_reg, out_vld_next;
    res_t out_data_reg;

    logic advance;
    logic step;
    cfg_t regs;
    res_t core_res;

    rhsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    rhsc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .hdr   (in_data_reg),
        .cfg   (regs),
        .res   (core_res)
    );

    assign advance      = !out_vld_reg || result.ready;
    assign step         = in_vld_reg && advance;
    assign header.ready = !in_vld_reg || advance;
    assign result.valid = out_vld_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (header.valid && header.ready)
            in_vld_next = 1'b1;
        else if (step)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (step)
            out_vld_next = 1'b1;
        else if (result.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (header.valid && header.ready)
            in_data_reg <= header.data;
        if (step)
            out_data_reg <= core_res;
    end

`ifndef SYNTHESIS
    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_vld_reg)
        else $error("processed header did not reach the result register");

    a_held_header: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_data_reg)))
        else $error("pending header lost while result stalled");

    a_open_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_data_reg.opens_block)
        |-> ((out_data_reg.block_start_kind != 3'd0)
             && (out_data_reg.block_bytes[31:16] == 16'd0)))
        else $error("new block without kind or with carried-over size");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for readout_header_stream_checker: streams page headers through
// the valid/ready channels, predicts every result in-line and compares field by field.
// Depends on rhsc_pkg, rhsc_hdr_if, rhsc_res_if, rhsc_cfg_if and the block's RTL.
module tb;
    import rhsc_pkg::*;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n;

    rhsc_hdr_if hdr_ch ();
    rhsc_res_if res_ch ();
    rhsc_cfg_if cfg_ch ();

    readout_header_stream_checker DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .header (hdr_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // register mirror and link state of the predictor
    cfg_t        link_cfg = '{CHECK_ENABLE_RST, ORBITS_PER_TF_RST, TF_MASK_RST, HB_MASK_RST};
    logic [15:0] lk_prev_fee     = '0;
    logic [15:0] lk_prev_page    = '0;
    logic [7:0]  lk_prev_packet  = '0;
    logic [31:0] lk_prev_orbit   = '0;
    logic [11:0] lk_prev_bc      = '0;
    logic [31:0] lk_pages_seen   = '0;
    logic [15:0] lk_hb_in_tf     = '0;
    logic        lk_hb_open      = 1'b0;
    logic [31:0] lk_tf_count     = '0;
    logic [31:0] lk_blk_bytes    = '0;
    logic [31:0] lk_blk_orbit    = '0;
    logic [31:0] lk_blk_tf_index = '0;
    logic [2:0]  lk_blk_kind     = '0;

    hdr_t pending_hdrs[$];
    res_t awaited_results[$];

    int unsigned hdrs_queued     = 0;
    int unsigned hdrs_accepted   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    logic [ERR_W-1:0] flags_seen = '0;
    logic [7:0]       kinds_seen = '0;

    logic        tx_idle_en = 1'b1;
    logic        rx_idle_en = 1'b1;
    int          hdr_gap_left = 0;
    int          rx_stall_left = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;

    // stream generator state
    logic [15:0] gen_fee;
    logic [7:0]  gen_packet;
    logic [31:0] gen_orbit;
    logic [11:0] gen_bc;

    function automatic res_t judge_header(input hdr_t h);
        res_t        r;
        logic [ERR_W-1:0] flags;
        logic        first;
        logic        new_tf;
        logic        new_hb;
        logic        opens;
        logic [15:0] next_page;
        logic [7:0]  next_packet;
        logic [31:0] next_orbit;
        logic [32:0] bytes_sum;
        flags       = '0;
        first       = (lk_pages_seen == 0);
        new_tf      = 1'b0;
        new_hb      = 1'b0;
        next_page   = lk_prev_page + 16'd1;
        next_packet = lk_prev_packet + 8'd1;
        next_orbit  = lk_prev_orbit + 32'd1;

        if (first)
            lk_prev_fee = h.fee_id;
        if (h.fee_id != lk_prev_fee)
            flags[ERR_FEE_ID] = 1'b1;

        if (h.page_counter == 16'd0)
        begin
            new_tf = (h.trigger_type & link_cfg.timeframe_trigger_mask) != 0;
            new_hb = (h.trigger_type & link_cfg.heartbeat_trigger_mask)
                     == link_cfg.heartbeat_trigger_mask;
        end
        else if (link_cfg.check_enable[CHK_PAGE_CNT] && !first && h.page_counter != next_page)
            flags[CHK_PAGE_CNT + 1] = 1'b1;

        if (link_cfg.check_enable != 0)
        begin
            if (!first)
            begin
                if (h.packet_counter != next_packet && link_cfg.check_enable[CHK_PACKET])
                    flags[CHK_PACKET + 1] = 1'b1;
                if (new_tf)
                begin
                    if (lk_hb_in_tf != link_cfg.orbits_per_timeframe
                        && link_cfg.check_enable[CHK_HB_PER_TF])
                        flags[CHK_HB_PER_TF + 1] = 1'b1;
                    lk_hb_in_tf = '0;
                end
            end
            else if ((!new_tf || !new_hb || h.page_counter != 0)
                     && link_cfg.check_enable[CHK_FIRST])
                flags[CHK_FIRST + 1] = 1'b1;
        end

        if (new_hb)
        begin
            if (link_cfg.check_enable != 0)
            begin
                if (lk_hb_in_tf != HB_PER_TF_MAX)
                    lk_hb_in_tf = lk_hb_in_tf + 16'd1;
                if (h.stop_bit && link_cfg.check_enable[CHK_STOP_1ST])
                    flags[CHK_STOP_1ST + 1] = 1'b1;
                if (lk_hb_open && link_cfg.check_enable[CHK_NO_STOP])
                    flags[CHK_NO_STOP + 1] = 1'b1;
                if (link_cfg.check_enable[CHK_JUMP] && !first
                    && !(h.heartbeat_bc == lk_prev_bc && h.heartbeat_orbit == next_orbit))
                    flags[CHK_JUMP + 1] = 1'b1;
            end
            lk_hb_open = 1'b1;
        end
        if (h.stop_bit)
            lk_hb_open = 1'b0;

        opens = new_tf || h.new_superpage || new_hb;
        if (opens)
        begin
            lk_blk_kind  = '0;
            lk_blk_bytes = '0;
            if (new_tf)
            begin
                lk_tf_count = lk_tf_count + 32'd1;
                lk_blk_kind[KIND_TF] = 1'b1;
                if (link_cfg.check_enable[CHK_NO_SP] && h.multi_link_stream && !h.new_superpage)
                    flags[CHK_NO_SP + 1] = 1'b1;
            end
            lk_blk_orbit    = h.heartbeat_orbit;
            lk_blk_tf_index = lk_tf_count - 32'd1;
            if (h.new_superpage)
                lk_blk_kind[KIND_SP] = 1'b1;
            if (new_hb)
                lk_blk_kind[KIND_HB] = 1'b1;
        end
        bytes_sum    = {1'b0, lk_blk_bytes} + {17'd0, h.page_bytes};
        lk_blk_bytes = bytes_sum[32] ? BYTES_MAX : bytes_sum[31:0];

        lk_prev_fee    = h.fee_id;
        lk_prev_page   = h.page_counter;
        lk_prev_packet = h.packet_counter;
        lk_prev_orbit  = h.heartbeat_orbit;
        lk_prev_bc     = h.heartbeat_bc;
        if (lk_pages_seen != 32'hffff_ffff)
            lk_pages_seen = lk_pages_seen + 32'd1;

        r.error_flags           = flags;
        r.opens_block           = opens;
        r.block_start_kind      = lk_blk_kind;
        r.block_orbit           = lk_blk_orbit;
        r.block_timeframe_index = lk_blk_tf_index;
        r.block_bytes           = lk_blk_bytes;
        r.heartbeat_ended       = h.stop_bit;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic hdr_t make_header(input logic [15:0] fee, input logic [15:0] page,
                                         input logic [7:0] packet, input logic [31:0] trig,
                                         input logic [31:0] orbit, input logic [11:0] bc,
                                         input logic stop, input logic [15:0] bytes,
                                         input logic sp, input logic multi);
        hdr_t h;
        h.fee_id            = fee;
        h.page_counter      = page;
        h.packet_counter    = packet;
        h.trigger_type      = trig;
        h.heartbeat_orbit   = orbit;
        h.heartbeat_bc      = bc;
        h.stop_bit          = stop;
        h.page_bytes        = bytes;
        h.new_superpage     = sp;
        h.multi_link_stream = multi;
        return h;
    endfunction

    task automatic queue_header(input hdr_t h);
        pending_hdrs.insert(pending_hdrs.size(), h);
        hdrs_queued++;
    endtask

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            note_failure($sformatf("result %0d: %s expected %h got %h",
                                   results_checked, name, want, got));
    endtask

    // Heartbeat frames of a healthy link with random content; a few pages are corrupted.
    task automatic queue_link_traffic(input int n_items);
        int          pushed;
        int          pages;
        int          hb_idx;
        int          tf_len;
        logic        is_tf;
        logic [31:0] tf_bits;
        logic [159:0] noise_bits;
        hdr_t        h;
        pushed = 0;
        hb_idx = 0;
        tf_len = (link_cfg.orbits_per_timeframe <= 16) ? int'(link_cfg.orbits_per_timeframe)
                                                        : $urandom_range(1, 8);
        while (pushed < n_items)
        begin
            pages = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
            is_tf = (hb_idx % tf_len == 0);
            for (int p = 0; p < pages; p++)
            begin
                h = make_header(gen_fee, 16'(p), gen_packet, $urandom, gen_orbit, gen_bc,
                                p == pages - 1, 16'($urandom), $urandom_range(0, 19) == 0,
                                1'($urandom_range(0, 1)));
                if (p == 0)
                begin
                    h.trigger_type = ($urandom & ~link_cfg.timeframe_trigger_mask)
                                     | link_cfg.heartbeat_trigger_mask;
                    if (is_tf)
                    begin
                        tf_bits = link_cfg.timeframe_trigger_mask & $urandom;
                        if (tf_bits == 0)
                            tf_bits = link_cfg.timeframe_trigger_mask;
                        h.trigger_type = h.trigger_type | tf_bits;
                    end
                    h.new_superpage = is_tf ? ($urandom_range(0, 9) != 0)
                                            : ($urandom_range(0, 9) == 0);
                end
                if ($urandom_range(0, 99) < 8)
                begin
                    case ($urandom_range(0, 6))
                        0: h.fee_id = 16'($urandom);
                        1: h.page_counter = 16'($urandom);
                        2: h.packet_counter = 8'($urandom);
                        3: h.stop_bit = !h.stop_bit;
                        4: h.trigger_type = $urandom;
                        5: h.heartbeat_orbit = $urandom;
                        default:
                        begin
                            noise_bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
                            h = noise_bits[$bits(hdr_t)-1:0];
                        end
                    endcase
                end
                queue_header(h);
                gen_packet++;
                pushed++;
            end
            hb_idx++;
            gen_orbit += ($urandom_range(0, 19) == 0) ? $urandom_range(2, 5) : 1;
            if ($urandom_range(0, 29) == 0)
                gen_bc = 12'($urandom);
            if ($urandom_range(0, 49) == 0)
                gen_fee = 16'($urandom);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_CHECK_ENABLE:  link_cfg.check_enable = value[7:0];
            CFG_ORBITS_PER_TF: link_cfg.orbits_per_timeframe = value[15:0];
            CFG_TF_MASK:       link_cfg.timeframe_trigger_mask = value;
            CFG_HB_MASK:       link_cfg.heartbeat_trigger_mask = value;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [7:0] chk, input logic [15:0] opt,
                                  input logic [31:0] tf_mask, input logic [31:0] hb_mask);
        write_reg(CFG_CHECK_ENABLE, {24'd0, chk});
        write_reg(CFG_ORBITS_PER_TF, {16'd0, opt});
        write_reg(CFG_TF_MASK, tf_mask);
        write_reg(CFG_HB_MASK, hb_mask);
    endtask

    task automatic wait_drained();
        while (hdrs_accepted != hdrs_queued || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // header driver
    always @(posedge clk)
    begin
        if (!rst_n)
            hdr_ch.valid <= 1'b0;
        else
        begin
            if (hdr_ch.valid && hdr_ch.ready)
            begin
                awaited_results.insert(awaited_results.size(), judge_header(hdr_ch.data));
                hdrs_accepted++;
            end
            if (!hdr_ch.valid || hdr_ch.ready)
            begin
                if (hdr_gap_left != 0)
                begin
                    hdr_gap_left <= hdr_gap_left - 1;
                    hdr_ch.valid <= 1'b0;
                end
                else if (pending_hdrs.size() != 0)
                begin
                    hdr_ch.data  <= pending_hdrs.pop_front();
                    hdr_ch.valid <= 1'b1;
                    hdr_gap_left <= tx_idle_en ? pick_gap() : 0;
                end
                else
                    hdr_ch.valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls plus the requested long hold
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_requests != holds_served)
        begin
            holds_served  <= hold_requests;
            rx_stall_left <= LONG_HOLD;
            res_ch.ready  <= 1'b0;
        end
        else if (rx_stall_left != 0)
        begin
            rx_stall_left <= rx_stall_left - 1;
            res_ch.ready  <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 99) < 25)
        begin
            rx_stall_left <= pick_gap();
            res_ch.ready  <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_results.size() == 0)
                note_failure($sformatf("result with no header pending: %h", res_ch.data));
            else
            begin
                want = awaited_results.pop_front();
                check_field("error_flags", 32'(want.error_flags),
                            32'(res_ch.data.error_flags));
                check_field("opens_block", 32'(want.opens_block),
                            32'(res_ch.data.opens_block));
                check_field("block_start_kind", 32'(want.block_start_kind),
                            32'(res_ch.data.block_start_kind));
                check_field("block_orbit", want.block_orbit, res_ch.data.block_orbit);
                check_field("block_timeframe_index", want.block_timeframe_index,
                            res_ch.data.block_timeframe_index);
                check_field("block_bytes", want.block_bytes, res_ch.data.block_bytes);
                check_field("heartbeat_ended", 32'(want.heartbeat_ended),
                            32'(res_ch.data.heartbeat_ended));
                flags_seen = flags_seen | want.error_flags;
                kinds_seen[want.block_start_kind] = 1'b1;
            end
            results_checked++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d of %0d headers taken, %0d results outstanding",
                 hdrs_accepted, hdrs_queued, awaited_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        hdr_ch.valid = 1'b0;
        hdr_ch.data  = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_CHECK_ENABLE;
        cfg_ch.wdata = '0;
        gen_fee      = 16'($urandom);
        gen_packet   = 8'($urandom);
        gen_orbit    = $urandom;
        gen_bc       = 12'($urandom);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers; first page opens nothing, then every check once
        queue_header(make_header(16'h0000, 16'd0, 8'hff, 32'h0, 32'hffff_fffd, 12'hfff,
                                 1'b0, 16'hffff, 1'b0, 1'b1));
        queue_header(make_header(16'h0000, 16'd1, 8'h00, 32'hffff_ffff, 32'hffff_fffd, 12'hfff,
                                 1'b0, 16'h0001, 1'b0, 1'b1));
        queue_header(make_header(16'h0000, 16'd2, 8'h01, 32'h0, 32'hffff_fffd, 12'hfff,
                                 1'b1, 16'h8000, 1'b0, 1'b0));
        queue_header(make_header(16'h0000, 16'd0, 8'h02, 32'h0000_0803, 32'hffff_fffe, 12'hfff,
                                 1'b0, 16'h0010, 1'b1, 1'b1));
        queue_header(make_header(16'h0000, 16'hffff, 8'h03, 32'h0, 32'hffff_ffff, 12'hfff,
                                 1'b0, 16'h0020, 1'b0, 1'b0));
        // orbit wraps to zero: no jump, but open frame and stop on first page
        queue_header(make_header(16'h0000, 16'd0, 8'h04, 32'h0000_0003, 32'h0, 12'hfff,
                                 1'b1, 16'h0030, 1'b0, 1'b0));
        queue_header(make_header(16'hffff, 16'd1, 8'h09, 32'h0, 32'h0, 12'hfff,
                                 1'b0, 16'h0001, 1'b0, 1'b0));
        queue_header(make_header(16'hffff, 16'd0, 8'h0a, 32'h0000_0800, 32'h5, 12'h000,
                                 1'b0, 16'h1234, 1'b0, 1'b1));
        queue_header(make_header(16'hffff, 16'd0, 8'h0b, 32'h0000_0002, 32'h5, 12'h000,
                                 1'b0, 16'h0040, 1'b1, 1'b0));
        queue_header(make_header(16'hffff, 16'd0, 8'h0c, 32'h0000_0003, 32'h7, 12'h000,
                                 1'b0, 16'h0002, 1'b0, 1'b0));
        queue_header(make_header(16'hffff, 16'd0, 8'h0d, 32'h7fff_ffff, 32'h8, 12'h001,
                                 1'b1, 16'h0003, 1'b0, 1'b1));
        queue_header(make_header(16'hffff, 16'd1, 8'h0e, 32'h0, 32'h8, 12'h001,
                                 1'b1, 16'hffff, 1'b0, 1'b0));
        queue_header(make_header(16'h5a5a, 16'd0, 8'h0f, 32'h0, 32'h9, 12'h001,
                                 1'b0, 16'h0050, 1'b0, 1'b1));
        queue_header(make_header(16'h5a5a, 16'd0, 8'h10, 32'hffff_ffff, 32'h9, 12'h001,
                                 1'b1, 16'h0000, 1'b1, 1'b1));
        wait_drained();

        // link traffic back to back, no stalls either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_all_regs(8'hff, 16'd4, TF_MASK_RST, HB_MASK_RST);
        queue_link_traffic(450);
        wait_drained();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        write_all_regs(8'($urandom), 16'd1, 32'h1 << $urandom_range(0, 31) | ($urandom & $urandom),
                       $urandom & $urandom & $urandom);
        queue_link_traffic(400);
        wait_drained();

        // checks off; zero heartbeat mask makes every first page a heartbeat start
        write_all_regs(8'h00, 16'hffff, 32'hffff_ffff, 32'h0);
        queue_link_traffic(300);
        wait_drained();

        write_all_regs(8'hff, 16'd2, 32'h0, 32'hffff_ffff);
        queue_link_traffic(400);
        wait_drained();

        // long receiver hold while headers keep coming
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        write_all_regs(8'($urandom), 16'd3, 32'h8000_0000, 32'h4000_0001);
        queue_link_traffic(400);
        while (pending_hdrs.size() > 350)
            @(posedge clk);
        hold_requests++;
        wait_drained();

        $display("%0d page headers sent, %0d results checked, %0d mismatches",
                 hdrs_accepted, results_checked, mismatches);
        $display("error flags raised: %b, block kinds seen (one-hot by kind): %b",
                 flags_seen, kinds_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
